// ===== sv/lmms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_pkg
// shared types and constants of the label mask block
// ----------------------------------------------------------------------------
package lmms_pkg;

    localparam int NUM_LABELS_DEF = 256;
    localparam int MAX_PIXELS_DEF = 65536;
    localparam int HIST_DEPTH     = 256;
    localparam int LABEL_W        = 8;
    localparam int COUNT_W        = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [7:0] MASK_ON  = 8'd255;
    localparam logic [7:0] MASK_OFF = 8'd0;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED_LABEL = 1'b1;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_READOUT = 1'b1;
    localparam logic RES_REPORT   = 1'b0;
    localparam logic RES_MASK     = 1'b1;
    localparam logic MODE_FIXED   = 1'b0;
    localparam logic MODE_LARGEST = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [LABEL_W-1:0] pixel_label;
        logic               end_of_frame;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [LABEL_W-1:0] target_label;
        logic [COUNT_W-1:0] target_count;
        logic [7:0]         mask_value;
        logic               last_pixel;
        logic               overrun;
    } t_out_item;

    typedef struct packed {
        logic               kind;
        logic [LABEL_W-1:0] label;
        logic               eof;
    } t_cmd;

endpackage

// ===== sv/lmms_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_stream_if
// valid/ready channel with a typed payload
// ----------------------------------------------------------------------------
interface lmms_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/label_mask_with_mode_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_mask_with_mode_select
// label frame store with histogram target pick and mask readout
// ----------------------------------------------------------------------------
// A pixel transfer does a histogram read-modify-write in the back end (on a
// single-port memory); the end-of-frame pixel then adds a histogram walk in
// largest mode or a read of the fixed label's entry in fixed mode, and a
// readout transfer goes through a registered frame-store read. A 2-entry
// command queue lets input transfers continue while a result waits at the
// output register. The histogram clears at frame close through per-entry valid
// bits; the frame store needs no clearing.
module label_mask_with_mode_select #(
    parameter int NUM_LABELS = lmms_pkg::NUM_LABELS_DEF,
    parameter int MAX_PIXELS = lmms_pkg::MAX_PIXELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [lmms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lmms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    lmms_stream_if.sink                     i_pix,
    lmms_stream_if.source                   o_res
);
    logic                         r_select_mode;
    logic [lmms_pkg::LABEL_W-1:0] r_fixed_label;
    lmms_pkg::t_cmd               cmd;
    logic                         cmd_valid, cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_select_mode <= lmms_pkg::MODE_FIXED;
            r_fixed_label <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lmms_pkg::CFG_SELECT_MODE: r_select_mode <= i_cfg_data[0];
                lmms_pkg::CFG_FIXED_LABEL: r_fixed_label <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lmms_front #(.NUM_LABELS(NUM_LABELS)) u_front (
        .i_clk, .i_rst_n, .i_pix,
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready)
    );

    lmms_back #(.NUM_LABELS(NUM_LABELS), .MAX_PIXELS(MAX_PIXELS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd(cmd), .i_cmd_valid(cmd_valid), .o_cmd_ready(cmd_ready),
        .i_select_mode(r_select_mode), .i_fixed_label(r_fixed_label), .o_res
    );

endmodule

// ===== sv/lmms_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_front
// accepts input items, clamps labels and queues commands for the back end
// ----------------------------------------------------------------------------
module lmms_front #(
    parameter int NUM_LABELS = lmms_pkg::NUM_LABELS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lmms_stream_if.sink       i_pix,
    output lmms_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready
);
    localparam int SPAN = (NUM_LABELS < lmms_pkg::HIST_DEPTH) ? NUM_LABELS
                                                              : lmms_pkg::HIST_DEPTH;

    lmms_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    lmms_pkg::t_cmd n_cmd;
    logic           push, pop;

    always_comb begin
        n_cmd.kind = i_pix.payload.kind;
        n_cmd.eof  = i_pix.payload.end_of_frame;
        if (9'(i_pix.payload.pixel_label) >= 9'(SPAN)) begin
            n_cmd.label = 8'(SPAN - 1);
        end else begin
            n_cmd.label = i_pix.payload.pixel_label;
        end
    end

    assign i_pix.ready = (r_cnt != 2'd2);
    assign push        = i_pix.valid && i_pix.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wp == r_rp))
        else $error("empty queue with pointers apart");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_valid && o_cmd.kind == lmms_pkg::KIND_PIXEL) |-> (9'(o_cmd.label) < 9'(SPAN)))
        else $error("queued label not clamped");

endmodule

// ===== sv/lmms_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmms_back
// frame store, histogram, target selection and mask readout
// ----------------------------------------------------------------------------
module lmms_back #(
    parameter int NUM_LABELS = lmms_pkg::NUM_LABELS_DEF,
    parameter int MAX_PIXELS = lmms_pkg::MAX_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lmms_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_ready,
    input  logic                        i_select_mode,
    input  logic [lmms_pkg::LABEL_W-1:0] i_fixed_label,
    lmms_stream_if.source               o_res
);
    localparam int SPAN = (NUM_LABELS < lmms_pkg::HIST_DEPTH) ? NUM_LABELS
                                                              : lmms_pkg::HIST_DEPTH;
    localparam int HW = $clog2(SPAN);
    localparam int PW = $clog2(MAX_PIXELS + 1);
    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = lmms_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE, S_PIX_UPD, S_SEL, S_SCAN, S_FIX_WAIT, S_CLOSE, S_RD_WAIT, S_EMIT
    } t_state;

    t_state                r_state, n_state;
    lmms_pkg::t_cmd        r_cmd, n_cmd;
    logic                  r_closed, n_closed;
    logic                  r_ovr, n_ovr;
    logic [PW-1:0]         r_total, n_total;
    logic [PW-1:0]         r_ptr, n_ptr;
    logic [7:0]            r_chosen, n_chosen;
    logic [HW-1:0]         r_scan, n_scan;
    logic [CW-1:0]         r_best, n_best;
    logic [7:0]            r_best_lab, n_best_lab;
    lmms_pkg::t_out_item   r_res, n_res;
    lmms_pkg::t_out_item   r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [CW-1:0]         r_hist [SPAN];
    logic [SPAN-1:0]       r_hvalid;
    logic [CW-1:0]         r_hq;
    logic                  r_hv_q;
    logic [7:0]            r_store [MAX_PIXELS];
    logic [7:0]            r_store_q;

    logic                  hrd_en, hwr_en, hclr, srd_en, swr_en;
    logic [HW-1:0]         hrd_addr, hwr_addr;
    logic [CW-1:0]         hwr_data, hval;
    logic [AW-1:0]         s_addr;
    logic [PW-1:0]         eff_total;

    assign hval      = r_hv_q ? r_hq : '0;
    assign eff_total = r_closed ? '0 : r_total;
    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_closed = r_closed; n_ovr = r_ovr;
        n_total = r_total; n_ptr = r_ptr; n_chosen = r_chosen; n_scan = r_scan;
        n_best = r_best; n_best_lab = r_best_lab; n_res = r_res;
        n_out = r_out; n_out_valid = r_out_valid && !o_res.ready;
        hrd_en = 1'b0; hrd_addr = '0; hwr_en = 1'b0; hwr_addr = r_cmd.label[HW-1:0];
        hwr_data = '0; hclr = 1'b0; srd_en = 1'b0; swr_en = 1'b0; s_addr = '0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    if (i_cmd.kind == lmms_pkg::KIND_PIXEL) begin
                        if (r_closed) begin
                            n_closed = 1'b0;
                            n_ptr    = '0;
                            n_ovr    = 1'b0;
                        end
                        if (eff_total < PW'(MAX_PIXELS)) begin
                            swr_en   = 1'b1;
                            s_addr   = eff_total[AW-1:0];
                            n_total  = eff_total + 1'b1;
                            hrd_en   = 1'b1;
                            hrd_addr = i_cmd.label[HW-1:0];
                            n_state  = S_PIX_UPD;
                        end else begin
                            n_total = eff_total;
                            n_ovr   = 1'b1;
                            n_state = i_cmd.eof ? S_SEL : S_IDLE;
                        end
                    end else if (r_closed && (r_ptr < r_total)) begin
                        srd_en  = 1'b1;
                        s_addr  = r_ptr[AW-1:0];
                        n_state = S_RD_WAIT;
                    end else begin
                        n_res = '{lmms_pkg::RES_MASK, r_chosen, '0, lmms_pkg::MASK_OFF,
                                  1'b0, 1'b1};
                        n_state = S_EMIT;
                    end
                end
            end
            S_PIX_UPD: begin
                hwr_en   = 1'b1;
                hwr_data = (hval < lmms_pkg::COUNT_MAX) ? hval + 1'b1 : hval;
                n_state  = r_cmd.eof ? S_SEL : S_IDLE;
            end
            S_SEL: begin
                n_best     = '0;
                n_best_lab = '0;
                if (i_select_mode == lmms_pkg::MODE_LARGEST) begin
                    n_scan   = '0;
                    hrd_en   = 1'b1;
                    hrd_addr = '0;
                    n_state  = S_SCAN;
                end else if (9'(i_fixed_label) < 9'(SPAN)) begin
                    hrd_en   = 1'b1;
                    hrd_addr = i_fixed_label[HW-1:0];
                    n_state  = S_FIX_WAIT;
                end else begin
                    n_best_lab = i_fixed_label;
                    n_state    = S_CLOSE;
                end
            end
            S_SCAN: begin
                if (hval > r_best) begin
                    n_best     = hval;
                    n_best_lab = 8'(r_scan);
                end
                if (r_scan == HW'(SPAN - 1)) begin
                    n_state = S_CLOSE;
                end else begin
                    n_scan   = r_scan + 1'b1;
                    hrd_en   = 1'b1;
                    hrd_addr = r_scan + 1'b1;
                end
            end
            S_FIX_WAIT: begin
                n_best     = hval;
                n_best_lab = i_fixed_label;
                n_state    = S_CLOSE;
            end
            S_CLOSE: begin
                hclr     = 1'b1;
                n_chosen = r_best_lab;
                n_closed = 1'b1;
                n_ptr    = '0;
                n_res    = '{lmms_pkg::RES_REPORT, r_best_lab, r_best, lmms_pkg::MASK_OFF,
                             1'b0, r_ovr};
                n_state  = S_EMIT;
            end
            S_RD_WAIT: begin
                n_res = '{lmms_pkg::RES_MASK, r_chosen, '0,
                          (r_store_q == r_chosen) ? lmms_pkg::MASK_ON : lmms_pkg::MASK_OFF,
                          (r_ptr + 1'b1 == r_total), 1'b0};
                n_ptr   = r_ptr + 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hrd_en) begin
            r_hq   <= r_hist[hrd_addr];
            r_hv_q <= r_hvalid[hrd_addr];
        end
        if (hwr_en) begin
            r_hist[hwr_addr] <= hwr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (swr_en) begin
            r_store[s_addr] <= n_cmd.label;
        end
        if (srd_en) begin
            r_store_q <= r_store[s_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid <= '0;
        end else if (hclr) begin
            r_hvalid <= '0;
        end else if (hwr_en) begin
            r_hvalid[hwr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_closed <= 1'b0; r_ovr <= 1'b0; r_total <= '0;
            r_ptr <= '0; r_chosen <= '0; r_out_valid <= 1'b0; r_scan <= '0;
        end else begin
            r_state <= n_state; r_closed <= n_closed; r_ovr <= n_ovr; r_total <= n_total;
            r_ptr <= n_ptr; r_chosen <= n_chosen; r_out_valid <= n_out_valid;
            r_scan <= n_scan;
        end
        r_cmd <= n_cmd; r_best <= n_best; r_best_lab <= n_best_lab;
        r_res <= n_res; r_out <= n_out;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_ptr <= r_total)
        else $error("readout pointer past frame end");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_total <= PW'(MAX_PIXELS))
        else $error("pixel total past store size");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLOSE) |=> (r_closed && r_hvalid == '0))
        else $error("histogram not cleared at frame close");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the label mask block
// ----------------------------------------------------------------------------
// Pixel frames and readout requests go in on the input channel and the bench
// predicts each frame report and mask pixel on its own. Every result transfer
// is compared field by field with the oldest prediction. A short table of
// directed rows comes first, then random frames with readouts and some noise,
// under three idling patterns.
module tb_top;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_op;

    typedef struct {
        t_row_op   op;
        lmms_pkg::t_in_item  item;
        bit        typed;
        lmms_pkg::t_out_item res;
        logic [lmms_pkg::CFG_IDX_W-1:0]  idx;
        logic [lmms_pkg::CFG_DATA_W-1:0] data;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [lmms_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [lmms_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    lmms_stream_if #(.t_payload(lmms_pkg::t_in_item))  pix_if ();
    lmms_stream_if #(.t_payload(lmms_pkg::t_out_item)) res_if ();

    label_mask_with_mode_select u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if.sink),
        .o_res      (res_if.source)
    );

    // model state
    logic [lmms_pkg::COUNT_W-1:0] hist [lmms_pkg::HIST_DEPTH];
    logic [lmms_pkg::LABEL_W-1:0] frame_mem [lmms_pkg::MAX_PIXELS_DEF];
    int unsigned        stored_cnt;
    int unsigned        read_ptr;
    logic [lmms_pkg::LABEL_W-1:0] pick_label;
    bit                 closed;
    bit                 dropped;
    logic               mode_reg;
    logic [lmms_pkg::LABEL_W-1:0] fixed_reg;

    lmms_pkg::t_out_item expected_q [$];
    int        errors;
    int        src_idle;
    int        snk_idle;
    t_row      rows [$];

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic predict_result(input lmms_pkg::t_in_item it, output bit has,
                                  output lmms_pkg::t_out_item r);
        int best;
        logic [lmms_pkg::COUNT_W-1:0] cnt;
        r = '0;
        has = 1'b0;
        if (it.kind == lmms_pkg::KIND_PIXEL) begin
            if (closed) begin
                closed = 1'b0;
                stored_cnt = 0;
                read_ptr = 0;
                dropped = 1'b0;
            end
            if (stored_cnt < lmms_pkg::MAX_PIXELS_DEF) begin
                frame_mem[stored_cnt] = it.pixel_label;
                stored_cnt++;
                if (hist[it.pixel_label] != lmms_pkg::COUNT_MAX) hist[it.pixel_label]++;
            end else begin
                dropped = 1'b1;
            end
            if (it.end_of_frame) begin
                if (mode_reg == lmms_pkg::MODE_LARGEST) begin
                    best = -1;
                    for (int i = 0; i < lmms_pkg::HIST_DEPTH; i++) begin
                        if (int'(hist[i]) > best) begin
                            best = hist[i];
                            pick_label = 8'(i);
                        end
                    end
                    cnt = 17'(best);
                end else begin
                    pick_label = fixed_reg;
                    cnt = hist[fixed_reg];
                end
                foreach (hist[i]) hist[i] = '0;
                read_ptr = 0;
                closed = 1'b1;
                has = 1'b1;
                r.result_kind = lmms_pkg::RES_REPORT;
                r.target_label = pick_label;
                r.target_count = cnt;
                r.overrun = dropped;
            end
        end else begin
            has = 1'b1;
            r.result_kind = lmms_pkg::RES_MASK;
            r.target_label = pick_label;
            if (closed && read_ptr < stored_cnt) begin
                r.mask_value = (frame_mem[read_ptr] == pick_label) ? lmms_pkg::MASK_ON
                                                                   : lmms_pkg::MASK_OFF;
                r.last_pixel = (read_ptr + 1 == stored_cnt);
                read_ptr++;
            end else begin
                r.overrun = 1'b1;
            end
        end
    endtask

    task automatic send_item(input lmms_pkg::t_in_item it, input bit typed,
                             input lmms_pkg::t_out_item typed_res);
        bit has;
        lmms_pkg::t_out_item r;
        if ($urandom_range(99) < src_idle) begin
            pix_if.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle);
        end
        pix_if.valid <= 1'b1;
        pix_if.payload <= it;
        @(posedge i_clk);
        while (!pix_if.ready) @(posedge i_clk);
        predict_result(it, has, r);
        if (has) expected_q.push_back(typed ? typed_res : r);
    endtask

    task automatic drain_and_wait();
        pix_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [lmms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lmms_pkg::CFG_DATA_W-1:0] data);
        drain_and_wait();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == lmms_pkg::CFG_SELECT_MODE) mode_reg = data[0];
        else fixed_reg = data;
    endtask

    function automatic lmms_pkg::t_in_item mk(logic k, logic [7:0] lab, logic e);
        lmms_pkg::t_in_item it;
        it.kind = k;
        it.pixel_label = lab;
        it.end_of_frame = e;
        return it;
    endfunction

    function automatic lmms_pkg::t_out_item mk_res(logic k, logic [7:0] lab,
                                                   logic [16:0] cnt, logic [7:0] m,
                                                   logic l, logic o);
        lmms_pkg::t_out_item r;
        r.result_kind = k;
        r.target_label = lab;
        r.target_count = cnt;
        r.mask_value = m;
        r.last_pixel = l;
        r.overrun = o;
        return r;
    endfunction

    function automatic t_row item_row(lmms_pkg::t_in_item it);
        t_row rw;
        rw.op = ROW_ITEM;
        rw.item = it;
        rw.typed = 1'b0;
        rw.res = '0;
        rw.idx = '0;
        rw.data = '0;
        return rw;
    endfunction

    function automatic t_row typed_row(lmms_pkg::t_in_item it, lmms_pkg::t_out_item r);
        t_row rw;
        rw = item_row(it);
        rw.typed = 1'b1;
        rw.res = r;
        return rw;
    endfunction

    function automatic t_row cfg_row(logic [lmms_pkg::CFG_IDX_W-1:0] idx,
                                     logic [lmms_pkg::CFG_DATA_W-1:0] d);
        t_row rw;
        rw = item_row('0);
        rw.op = ROW_CFG;
        rw.idx = idx;
        rw.data = d;
        return rw;
    endfunction

    function automatic logic [7:0] rand_label(int spread);
        return (spread == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(spread));
    endfunction

    // one frame, then readouts that may stop short or run past the end
    task automatic random_frame(output int n_items);
        int n;
        int spread;
        int reads;
        n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        spread = ($urandom_range(2) == 0) ? 0 : $urandom_range(4, 1);
        if ($urandom_range(3) == 0) spread = 255;
        for (int i = 0; i < n; i++) begin
            send_item(mk(lmms_pkg::KIND_PIXEL, rand_label(spread), i == n - 1), 1'b0, '0);
        end
        reads = ($urandom_range(4) == 0) ? $urandom_range(n) : n + $urandom_range(2);
        for (int i = 0; i < reads; i++) begin
            send_item(mk(lmms_pkg::KIND_READOUT, 8'($urandom), 1'($urandom)), 1'b0, '0);
        end
        n_items = n + reads;
    endtask

    task automatic random_noise(output int n_items);
        n_items = $urandom_range(4, 1);
        for (int i = 0; i < n_items; i++) begin
            send_item(mk(1'($urandom), 8'($urandom), 1'($urandom)), 1'b0, '0);
        end
    endtask

    task automatic random_phase(input int target);
        int sent;
        int k;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(99) < 12) random_noise(k);
            else random_frame(k);
            sent += k;
            if ($urandom_range(99) < 10) begin
                case ($urandom_range(3))
                    0: write_reg(lmms_pkg::CFG_SELECT_MODE, {7'd0, 1'($urandom)});
                    1: write_reg(lmms_pkg::CFG_FIXED_LABEL, 8'd0);
                    2: write_reg(lmms_pkg::CFG_FIXED_LABEL, 8'd255);
                    default: write_reg(lmms_pkg::CFG_FIXED_LABEL, 8'($urandom_range(4)));
                endcase
            end
        end
    endtask

    task automatic field_check(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        lmms_pkg::t_out_item e;
        lmms_pkg::t_out_item a;
        if (res_if.valid && res_if.ready) begin
            a = res_if.payload;
            if (expected_q.size() == 0) begin
                $display("%0t unexpected result transfer actual %h", $time, a);
                errors++;
            end else begin
                e = expected_q.pop_front();
                field_check("result_kind", e.result_kind, a.result_kind);
                field_check("target_label", e.target_label, a.target_label);
                field_check("target_count", e.target_count, a.target_count);
                field_check("mask_value", e.mask_value, a.mask_value);
                field_check("last_pixel", e.last_pixel, a.last_pixel);
                field_check("overrun", e.overrun, a.overrun);
            end
        end
        res_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    initial begin
        int n;
        pix_if.valid = 1'b0;
        pix_if.payload = '0;
        res_if.ready = 1'b0;
        errors = 0;
        src_idle = 16;
        snk_idle = 58;
        foreach (hist[i]) hist[i] = '0;
        stored_cnt = 0;
        read_ptr = 0;
        pick_label = '0;
        closed = 1'b0;
        dropped = 1'b0;
        mode_reg = lmms_pkg::MODE_FIXED;
        fixed_reg = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows
        rows.push_back(typed_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0),
                                 mk_res(lmms_pkg::RES_MASK, 8'd0, 17'd0,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b1)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_PIXEL, 8'd0, 1'b1),
                                 mk_res(lmms_pkg::RES_REPORT, 8'd0, 17'd1,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0),
                                 mk_res(lmms_pkg::RES_MASK, 8'd0, 17'd0,
                                        lmms_pkg::MASK_ON, 1'b1, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0),
                                 mk_res(lmms_pkg::RES_MASK, 8'd0, 17'd0,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b1)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_PIXEL, 8'd255, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b1),
                                 mk_res(lmms_pkg::RES_MASK, 8'd0, 17'd0,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b1)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_PIXEL, 8'd170, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_PIXEL, 8'd85, 1'b1),
                                 mk_res(lmms_pkg::RES_REPORT, 8'd0, 17'd0,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_READOUT, 8'd255, 1'b1)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0)));
        rows.push_back(cfg_row(lmms_pkg::CFG_FIXED_LABEL, 8'd255));
        rows.push_back(item_row(mk(lmms_pkg::KIND_PIXEL, 8'd255, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_PIXEL, 8'd255, 1'b1),
                                 mk_res(lmms_pkg::RES_REPORT, 8'd255, 17'd2,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0)));
        rows.push_back(cfg_row(lmms_pkg::CFG_SELECT_MODE, {7'd0, lmms_pkg::MODE_LARGEST}));
        rows.push_back(item_row(mk(lmms_pkg::KIND_PIXEL, 8'd7, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_PIXEL, 8'd3, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_PIXEL, 8'd3, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_PIXEL, 8'd7, 1'b1),
                                 mk_res(lmms_pkg::RES_REPORT, 8'd3, 17'd2,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0)));
        rows.push_back(item_row(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0)));
        rows.push_back(typed_row(mk(lmms_pkg::KIND_PIXEL, 8'd255, 1'b1),
                                 mk_res(lmms_pkg::RES_REPORT, 8'd255, 17'd1,
                                        lmms_pkg::MASK_OFF, 1'b0, 1'b0)));

        foreach (rows[i]) begin
            if (rows[i].op == ROW_CFG) write_reg(rows[i].idx, rows[i].data);
            else send_item(rows[i].item, rows[i].typed, rows[i].res);
        end

        random_phase(400);
        src_idle = 58;
        snk_idle = 16;
        random_phase(400);
        src_idle = 0;
        snk_idle = 0;
        random_phase(400);

        for (int i = 0; i < 3; i++) begin
            send_item(mk(lmms_pkg::KIND_READOUT, 8'd0, 1'b0), 1'b0, '0);
        end
        random_frame(n);

        drain_and_wait();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

// ===== label_mask_with_mode_select.f =====
sv/lmms_pkg.sv
sv/lmms_stream_if.sv
sv/lmms_front.sv
sv/lmms_back.sv
sv/label_mask_with_mode_select.sv
tb/tb_top.sv
